>>> sv/dpht_pkg.sv
`default_nettype none

package dpht_pkg;

  typedef logic        [63:0] dpht_key_t;
  typedef logic signed [15:0] dpht_score_t;
  typedef logic        [7:0]  dpht_depth_t;
  typedef logic        [47:0] dpht_nodes_t;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_PROBE = 1'b1
  } dpht_op_e;

  // One table slot as held in the RAM. A cleared slot is all zero.
  typedef struct packed {
    logic        valid;
    dpht_key_t   key;
    dpht_score_t score;
    dpht_depth_t depth;
    dpht_nodes_t nodes;
  } dpht_entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } dpht_state_e;

  // Controller to datapath
  typedef struct packed {
    logic clr_step;  // zero the slot at the sweep pointer, advance it
    logic accept;    // capture request, launch slot read
    logic commit;    // update slot, load response register
  } dpht_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_done;  // sweep pointer is on the last slot
    logic out_free;  // response register can take a new response
  } dpht_sts_t;

endpackage

`default_nettype wire

>>> sv/dpht_intf.sv
`default_nettype none

interface dpht_req_if
  import dpht_pkg::*;
();
  logic        valid;
  logic        ready;
  logic        operation;
  dpht_key_t   key;
  dpht_score_t entry_score;
  dpht_depth_t entry_depth;
  dpht_nodes_t entry_nodes;

  modport source (
    output valid, operation, key, entry_score, entry_depth, entry_nodes,
    input  ready
  );
  modport sink (
    input  valid, operation, key, entry_score, entry_depth, entry_nodes,
    output ready
  );
endinterface

interface dpht_rsp_if
  import dpht_pkg::*;
();
  logic        valid;
  logic        ready;
  logic        hit;
  logic        written;
  dpht_score_t found_score;
  dpht_depth_t found_depth;
  dpht_nodes_t found_nodes;

  modport source (
    output valid, hit, written, found_score, found_depth, found_nodes,
    input  ready
  );
  modport sink (
    input  valid, hit, written, found_score, found_depth, found_nodes,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/dpht_ram.sv
`default_nettype none

module dpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/dpht_ctrl.sv
`default_nettype none

module dpht_ctrl
  import dpht_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire dpht_sts_t sts_i,
  output dpht_cmd_t      cmd_o
);

  dpht_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // wait here while the previous response is still unclaimed
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/dpht_datapath.sv
`default_nettype none

module dpht_datapath
  import dpht_pkg::*;
#(
  parameter int TABLE_ENTRIES = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dpht_cmd_t   cmd_i,
  output dpht_sts_t        sts_o,
  input  wire logic        req_operation_i,
  input  wire dpht_key_t   req_key_i,
  input  wire dpht_score_t req_score_i,
  input  wire dpht_depth_t req_depth_i,
  input  wire dpht_nodes_t req_nodes_i,
  input  wire logic        rsp_ready_i,
  output logic             rsp_valid_o,
  output logic             rsp_hit_o,
  output logic             rsp_written_o,
  output dpht_score_t      rsp_score_o,
  output dpht_depth_t      rsp_depth_o,
  output dpht_nodes_t      rsp_nodes_o
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int ENTRY_W = $bits(dpht_entry_t);
  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  // captured request
  dpht_op_e    op_q;
  dpht_key_t   key_q;
  dpht_score_t score_q;
  dpht_depth_t depth_q;
  dpht_nodes_t nodes_q;
  logic [IDX_W-1:0] idx_q;

  logic [IDX_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [IDX_W-1:0] rd_idx;

  logic [ENTRY_W-1:0] ram_rdata;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_waddr;
  logic               ram_we;

  dpht_entry_t slot, new_entry, found;
  logic        do_write;
  logic        hit;

  // response register
  logic        rsp_valid_q, rsp_valid_d;
  logic        rsp_hit_q, rsp_written_q;
  dpht_entry_t rsp_entry_q;

  assign rd_idx = req_key_i[IDX_W-1:0] & IDX_MASK;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q    <= dpht_op_e'(req_operation_i);
      key_q   <= req_key_i;
      score_q <= req_score_i;
      depth_q <= req_depth_i;
      nodes_q <= req_nodes_i;
      idx_q   <= rd_idx;
    end
  end

  // sweep pointer for the clearing pass after reset
  assign clr_cnt_d = cmd_i.clr_step ? clr_cnt_q + 1'b1 : clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Read data is the slot as it stood at accept; a cleared slot is all zero,
  // so an empty slot reports zero score, depth and nodes without a mux.
  assign slot = dpht_entry_t'(ram_rdata);

  always_comb begin
    new_entry.valid = 1'b1;
    new_entry.key   = key_q;
    new_entry.score = score_q;
    new_entry.depth = depth_q;
    new_entry.nodes = nodes_q;
  end

  assign do_write = (op_q == OP_STORE) && (!slot.valid || (depth_q > slot.depth));
  assign hit      = (op_q == OP_PROBE) && slot.valid && (slot.key == key_q);
  assign found    = do_write ? new_entry : slot;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = ENTRY_W'(new_entry);
    if (cmd_i.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else if (cmd_i.commit) begin
      ram_we = do_write;
    end
  end

  dpht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (rd_idx),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd_i.commit) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rsp_hit_q     <= hit;
      rsp_written_q <= do_write;
      rsp_entry_q   <= found;
    end
  end

  assign sts_o.clr_done = (clr_cnt_q == IDX_LAST);
  assign sts_o.out_free = !rsp_valid_q || rsp_ready_i;

  assign rsp_valid_o   = rsp_valid_q;
  assign rsp_hit_o     = rsp_hit_q;
  assign rsp_written_o = rsp_written_q;
  assign rsp_score_o   = rsp_entry_q.score;
  assign rsp_depth_o   = rsp_entry_q.depth;
  assign rsp_nodes_o   = rsp_entry_q.nodes;

endmodule

`default_nettype wire

>>> sv/depth_preferred_hash_table_core.sv
// Channel | Dir | Payload                                             | Handshake
// req_i   | in  | operation, key, entry_score, entry_depth, entry_nodes | valid/ready
// rsp_o   | out | hit, written, found_score, found_depth, found_nodes   | valid/ready
//
// The accept cycle launches the slot read, and ST_LOOKUP then does the
// read-modify-write on the table RAM, with its own read and write ports.
// After reset a clearing pass zeroes every slot, with req_i.ready low. The
// response sits in an output register; the next request is accepted while
// it waits, and its lookup holds until the register frees.
`default_nettype none

module depth_preferred_hash_table_core
  import dpht_pkg::*;
#(
  parameter int TABLE_ENTRIES = 4096
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dpht_req_if.sink    req_i,
  dpht_rsp_if.source  rsp_o
);

  dpht_cmd_t cmd;
  dpht_sts_t sts;
  logic      in_ready;

  // sequencing: clear sweep, accept, lookup/commit
  dpht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign req_i.ready = in_ready;

  // table RAM, replacement decision and response register
  dpht_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_operation_i (req_i.operation),
    .req_key_i       (req_i.key),
    .req_score_i     (req_i.entry_score),
    .req_depth_i     (req_i.entry_depth),
    .req_nodes_i     (req_i.entry_nodes),
    .rsp_ready_i     (rsp_o.ready),
    .rsp_valid_o     (rsp_o.valid),
    .rsp_hit_o       (rsp_o.hit),
    .rsp_written_o   (rsp_o.written),
    .rsp_score_o     (rsp_o.found_score),
    .rsp_depth_o     (rsp_o.found_depth),
    .rsp_nodes_o     (rsp_o.found_nodes)
  );

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb
  import dpht_pkg::*;
();

  localparam int TABLE_ENTRIES = 4096;
  localparam int HOT_SLOTS     = 64;    // narrow index range to force collisions
  localparam int KEY_POOL      = 32;    // recently stored keys, reused by probes
  localparam int STALL_AT_RSP  = 1200;  // response count that starts the long hold-off
  localparam int STALL_CYCLES  = 400;
  localparam int WATCHDOG_MAX  = 20000; // covers the clearing pass and the hold-off
  localparam int TAIL_CYCLES   = 8;

  // Fields of one response, as the table should report it.
  typedef struct {
    logic        hit;
    logic        written;
    dpht_score_t score;
    dpht_depth_t depth;
    dpht_nodes_t nodes;
  } slot_report_t;

  // Shadow copy of the table plus the responses still owed by the block.
  class slot_table_scoreboard;
    bit          occupied   [TABLE_ENTRIES];
    dpht_key_t   tag        [TABLE_ENTRIES];
    dpht_score_t score_mem  [TABLE_ENTRIES];
    dpht_depth_t depth_mem  [TABLE_ENTRIES];
    dpht_nodes_t nodes_mem  [TABLE_ENTRIES];
    slot_report_t owed_reports[$];
    int unsigned  fault_count;

    function new();
      foreach (occupied[i]) occupied[i] = 1'b0;
      fault_count = 0;
    endfunction

    // Apply an accepted request to the shadow table and queue its report.
    function void note_request(dpht_op_e op, dpht_key_t key, dpht_score_t score,
                               dpht_depth_t depth, dpht_nodes_t nodes);
      int unsigned  idx;
      slot_report_t r;
      idx       = int'(key & 64'(TABLE_ENTRIES - 1));
      r.hit     = 1'b0;
      r.written = 1'b0;
      if (op == OP_STORE) begin
        // depth-preferred: fill when empty, replace only on strictly deeper
        if (!occupied[idx] || depth > depth_mem[idx]) begin
          occupied[idx]  = 1'b1;
          tag[idx]       = key;
          score_mem[idx] = score;
          depth_mem[idx] = depth;
          nodes_mem[idx] = nodes;
          r.written      = 1'b1;
        end
      end else begin
        r.hit = occupied[idx] && (tag[idx] == key);
      end
      if (occupied[idx]) begin
        r.score = score_mem[idx];
        r.depth = depth_mem[idx];
        r.nodes = nodes_mem[idx];
      end else begin
        r.score = '0;
        r.depth = '0;
        r.nodes = '0;
      end
      owed_reports.push_back(r);
    endfunction

    function void check_response(logic hit, logic written, dpht_score_t score,
                                 dpht_depth_t depth, dpht_nodes_t nodes);
      slot_report_t e;
      if (owed_reports.size() == 0) begin
        $error("response with no request outstanding");
        fault_count++;
        return;
      end
      e = owed_reports.pop_front();
      if (hit !== e.hit) begin
        $error("hit: expected %0d, got %0d", e.hit, hit);
        fault_count++;
      end
      if (written !== e.written) begin
        $error("written: expected %0d, got %0d", e.written, written);
        fault_count++;
      end
      if (score !== e.score) begin
        $error("found_score: expected %0d, got %0d", e.score, score);
        fault_count++;
      end
      if (depth !== e.depth) begin
        $error("found_depth: expected %0d, got %0d", e.depth, depth);
        fault_count++;
      end
      if (nodes !== e.nodes) begin
        $error("found_nodes: expected %0h, got %0h", e.nodes, nodes);
        fault_count++;
      end
    endfunction

    function int unsigned owed();
      return owed_reports.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  dpht_req_if req_if ();
  dpht_rsp_if rsp_if ();

  depth_preferred_hash_table_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  slot_table_scoreboard sb = new();

  // Idle odds in percent. The receiver's is written with NBAs so that its
  // process always sees a stable value at the edge.
  int unsigned req_idle_pct = 0;
  int unsigned rsp_idle_pct = 0;

  dpht_key_t key_pool [KEY_POOL];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Response side: check every accepted response, then pick ready for the
  // next cycle. Once, deep into the run, ready is held low for a long stretch
  // so that the output register and the lookup stage back up and the block
  // drops req ready while the sender keeps offering.
  initial begin
    int unsigned rsp_seen;
    int unsigned hold_left;
    rsp_seen  = 0;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        sb.check_response(rsp_if.hit, rsp_if.written, rsp_if.found_score,
                          rsp_if.found_depth, rsp_if.found_nodes);
        rsp_seen++;
        if (rsp_seen == STALL_AT_RSP) hold_left = STALL_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
    end
  end

  // Watchdog: cycles in a row with no handshake on either channel.
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_MAX) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Offer one request, idling first at the current odds. valid stays high
  // from one request to the next unless an idle cycle falls between them.
  task automatic send_request(dpht_op_e op, dpht_key_t key, dpht_score_t score,
                              dpht_depth_t depth, dpht_nodes_t nodes);
    while ($urandom_range(99) < req_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.operation   <= op;
    req_if.key         <= key;
    req_if.entry_score <= score;
    req_if.entry_depth <= depth;
    req_if.entry_nodes <= nodes;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sb.note_request(op, key, score, depth, nodes);
  endtask

  // Stop offering and wait for every owed response.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.owed() != 0) @(posedge clk_i);
  endtask

  // Mostly well-formed traffic: probes of keys recently stored, stores that
  // collide on a handful of hot slots, plus fully random keys for bit cover.
  task automatic send_random_request();
    dpht_op_e    op;
    dpht_key_t   key;
    dpht_depth_t depth;
    int unsigned pick;
    op   = ($urandom_range(1) == 0) ? OP_STORE : OP_PROBE;
    pick = $urandom_range(99);
    if (op == OP_PROBE && pick < 70) begin
      key = key_pool[$urandom_range(KEY_POOL - 1)];
    end else if (pick < 80) begin
      key = {$urandom, $urandom};
    end else begin
      key = {$urandom, 20'($urandom), 12'($urandom_range(HOT_SLOTS - 1))};
    end
    if (op == OP_STORE) key_pool[$urandom_range(KEY_POOL - 1)] = key;
    // narrow depth range now and then so equal depths come up often
    depth = ($urandom_range(3) == 0) ? 8'($urandom_range(4)) : 8'($urandom);
    send_request(op, key, 16'($urandom), depth, {16'($urandom), 32'($urandom)});
  endtask

  task automatic run_phase(int unsigned count, int unsigned req_pct,
                           int unsigned rsp_pct);
    req_idle_pct = req_pct;
    rsp_idle_pct <= rsp_pct;
    repeat (count) send_random_request();
    drain();
  endtask

  localparam dpht_key_t KEY_A  = 64'h0123_4567_89AB_C005;
  localparam dpht_key_t KEY_B  = 64'hFEDC_BA98_7654_3005;  // same slot as KEY_A
  localparam dpht_key_t KEY_C  = 64'h5555_AAAA_0F0F_F00D;
  localparam dpht_key_t ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam dpht_key_t ONES_H = 64'h7FFF_FFFF_FFFF_FFFF;  // same slot as ONES
  localparam dpht_nodes_t NODES_MAX = 48'hFFFF_FFFF_FFFF;

  initial begin
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.operation   <= OP_STORE;
    req_if.key         <= '0;
    req_if.entry_score <= '0;
    req_if.entry_depth <= '0;
    req_if.entry_nodes <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, back to back so that store/probe pairs on one slot
    // exercise back-to-back read-modify-write on that slot.
    send_request(OP_PROBE, KEY_A, 16'sd0, 8'd0, 48'd0);        // empty slot
    send_request(OP_STORE, KEY_A, 16'sd32767, 8'd10, NODES_MAX);
    send_request(OP_PROBE, KEY_A, 16'sd0, 8'd0, 48'd0);        // hit
    send_request(OP_PROBE, KEY_B, 16'sd0, 8'd0, 48'd0);        // miss, data reported
    send_request(OP_STORE, KEY_B, 16'sd1, 8'd10, 48'd1);       // equal depth: kept
    send_request(OP_STORE, KEY_B, 16'sd2, 8'd9, 48'd2);        // shallower: kept
    send_request(OP_STORE, KEY_B, -16'sd32768, 8'd11, 48'd0);  // deeper, other key
    send_request(OP_PROBE, KEY_A, 16'sd0, 8'd0, 48'd0);        // evicted key misses
    send_request(OP_PROBE, KEY_B, 16'sd0, 8'd0, 48'd0);
    send_request(OP_STORE, 64'd0, 16'sd0, 8'd0, 48'd0);        // depth 0 into empty
    send_request(OP_STORE, 64'h1000, 16'sd5, 8'd0, 48'd5);     // equal depth 0: kept
    send_request(OP_PROBE, 64'd0, 16'sd0, 8'd0, 48'd0);
    send_request(OP_STORE, 64'h1000, 16'sd7, 8'd1, 48'd7);     // deeper: replaces
    send_request(OP_PROBE, 64'd0, 16'sd0, 8'd0, 48'd0);
    send_request(OP_PROBE, 64'h1000, 16'sd0, 8'd0, 48'd0);
    send_request(OP_STORE, ONES, -16'sd1, 8'd255, NODES_MAX);
    send_request(OP_STORE, ONES_H, 16'sd3, 8'd255, 48'd3);     // saturated depth: kept
    send_request(OP_PROBE, ONES, 16'sd0, 8'd0, 48'd0);
    send_request(OP_PROBE, ONES_H, 16'sd0, 8'd0, 48'd0);
    send_request(OP_STORE, KEY_C, 16'sd100, 8'd5, 48'h8000_0000_0001);
    send_request(OP_PROBE, KEY_C, 16'sd0, 8'd0, 48'd0);
    drain();

    run_phase(530, 31, 87);
    run_phase(530, 87, 31);
    run_phase(540, 0, 0);   // the long receiver hold-off lands in here

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.fault_count == 0 && sb.owed() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
